### hw/rtl/ttw_pkg.sv
// Shared types and constants for the text terminal writer.
// Request and result payload structs, character and command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

  localparam logic       CMD_PUT      = 1'b0;
  localparam logic       CMD_READ     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] COLOR_RESET  = 8'h07;

  typedef struct packed {
    logic        command;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/text_terminal_writer_core.sv
// Text terminal writer: screen cell store in one synchronous RAM plus cursor.
// Flow: one result per request; reads and scrolling puts keep busy high until their result,
// while plain puts leave the core idle. The sweep over the RAM port sets the scroll time.
// Reset: a clear pass writes blank grey cells over the whole store, with busy high.
// Results are one-cycle strobes; the receiver cannot stall.
// Depends on ttw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ttw_pkg::req_t in_req,
  output logic               out_strobe,
  output ttw_pkg::rsp_t      out_rsp,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_SCROLL} state_t;

  state_t        state_r;
  logic [AW-1:0] ptr_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [7:0]    color_r;
  logic          rd_oob_r;
  logic          out_strobe_r;
  ttw_pkg::rsp_t out_rsp_r;

  logic [15:0]   mem [0:CELLS-1];
  logic [15:0]   rd_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [AW-1:0] mem_ra;

  logic          accept;
  logic          is_newline;
  logic          col_wrap;
  logic          row_adv;
  logic          row_last;
  logic          idx_ok;
  logic [AW-1:0] cur_pos;
  logic [AW:0]   nxt_src;
  logic          nxt_src_ok;
  logic          ptr_last;
  logic [15:0]   blank;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign is_newline = (in_req.char_code == ttw_pkg::NEWLINE_CODE);
  assign col_wrap   = (col_r == CW'(COLUMNS - 1));
  assign row_adv    = is_newline || col_wrap;
  assign row_last   = (row_r == RW'(ROWS - 1));
  assign idx_ok     = ({21'd0, in_req.read_index} < 32'(CELLS));
  assign cur_pos    = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign nxt_src    = {1'b0, ptr_r} + (AW+1)'(COLUMNS + 1);
  assign nxt_src_ok = (nxt_src < (AW+1)'(CELLS));
  assign ptr_last   = (ptr_r == AW'(CELLS - 1));
  assign blank      = {color_r, ttw_pkg::SPACE_CODE};

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r;
    mem_wd = blank;
    mem_ra = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = {ttw_pkg::COLOR_RESET, ttw_pkg::SPACE_CODE};
      end
      ST_IDLE: begin
        if (in_req.command == ttw_pkg::CMD_READ) begin
          mem_ra = AW'(in_req.read_index);
        end else begin
          mem_ra = AW'(COLUMNS);
          mem_we = accept && !is_newline;
          mem_wa = cur_pos;
          mem_wd = {color_r, in_req.char_code};
        end
      end
      ST_SCROLL: begin
        mem_we = 1'b1;
        if (ptr_r < AW'(CELLS - COLUMNS)) begin
          mem_wd = rd_data_r;
        end
        if (nxt_src_ok) begin
          mem_ra = AW'(nxt_src);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= ttw_pkg::COLOR_RESET;
    end else if (cfg_we) begin
      color_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      ptr_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      rd_oob_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      out_rsp_r    <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          ptr_r <= ptr_r + AW'(1);
          if (ptr_last) begin
            ptr_r   <= '0;
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_req.command == ttw_pkg::CMD_READ) begin
              rd_oob_r <= !idx_ok;
              state_r  <= ST_READ;
            end else begin
              out_rsp_r.cell_value <= '0;
              out_rsp_r.scrolled   <= 1'b0;
              if (row_adv) begin
                col_r                <= '0;
                out_rsp_r.cursor_col <= '0;
                if (row_last) begin
                  ptr_r   <= '0;
                  state_r <= ST_SCROLL;
                end else begin
                  row_r                <= row_r + RW'(1);
                  out_rsp_r.cursor_row <= 5'(row_r + RW'(1));
                  out_strobe_r         <= 1'b1;
                end
              end else begin
                col_r                <= col_r + CW'(1);
                out_rsp_r.cursor_col <= 7'(col_r + CW'(1));
                out_rsp_r.cursor_row <= 5'(row_r);
                out_strobe_r         <= 1'b1;
              end
            end
          end
        end
        ST_READ: begin
          out_rsp_r.cell_value <= rd_oob_r ? 16'd0 : rd_data_r;
          out_rsp_r.cursor_row <= 5'(row_r);
          out_rsp_r.cursor_col <= 7'(col_r);
          out_rsp_r.scrolled   <= 1'b0;
          out_strobe_r         <= 1'b1;
          state_r              <= ST_IDLE;
        end
        ST_SCROLL: begin
          ptr_r <= ptr_r + AW'(1);
          if (ptr_last) begin
            ptr_r                <= '0;
            out_rsp_r.cell_value <= '0;
            out_rsp_r.cursor_row <= 5'(row_r);
            out_rsp_r.cursor_col <= '0;
            out_rsp_r.scrolled   <= 1'b1;
            out_strobe_r         <= 1'b1;
            state_r              <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/tb_text_terminal_writer_core.sv
// Testbench for text_terminal_writer_core: directed table, then random put/read requests.
// Checks every result against the table's expectation or a local screen and cursor model.
// Depends on ttw_pkg and text_terminal_writer_core.
`timescale 1ns / 1ps

module tb_text_terminal_writer_core;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int N_PHASE     = 4;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    ttw_pkg::req_t req;
    logic          has_exp;
    ttw_pkg::rsp_t exp;
  } dir_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  ttw_pkg::req_t in_req;
  logic          out_strobe;
  ttw_pkg::rsp_t out_rsp;
  logic          cfg_we;
  logic [7:0]    cfg_wdata;

  // typed expectation that travels with the request being offered
  logic          cur_has_exp;
  ttw_pkg::rsp_t cur_exp;

  logic [15:0] screen_mem [0:CELLS-1];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  text_attr;

  ttw_pkg::rsp_t screen_rsp_q[$];
  dir_row_t      dir_tab[$];
  int            mismatch_cnt;
  int            stall_cnt;

  text_terminal_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic advance_row();
    int i;
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    for (i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
    for (i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = {text_attr, ttw_pkg::SPACE_CODE};
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic ttw_pkg::rsp_t terminal_step(ttw_pkg::req_t r);
    ttw_pkg::rsp_t o;
    int            pos;
    o = '0;
    if (r.command == ttw_pkg::CMD_READ) begin
      if (r.read_index < CELLS) o.cell_value = screen_mem[r.read_index];
    end else if (r.char_code == ttw_pkg::NEWLINE_CODE) begin
      cur_col = 0;
      o.scrolled = advance_row();
    end else begin
      pos = cur_row * COLUMNS + cur_col;
      screen_mem[pos] = {text_attr, r.char_code};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        o.scrolled = advance_row();
      end
    end
    o.cursor_row = cur_row[4:0];
    o.cursor_col = cur_col[6:0];
    return o;
  endfunction

  function automatic ttw_pkg::req_t rand_request(int nl_pct);
    ttw_pkg::req_t r;
    r.read_index = 11'($urandom_range(0, 2047));
    r.char_code  = 8'($urandom_range(0, 255));
    r.command    = ($urandom_range(0, 99) < 20) ? ttw_pkg::CMD_READ : ttw_pkg::CMD_PUT;
    if (r.command == ttw_pkg::CMD_READ) begin
      // mostly look at the row being written
      if ($urandom_range(0, 99) < 60)
        r.read_index = 11'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
    end else if ($urandom_range(0, 99) < nl_pct) begin
      r.char_code = ttw_pkg::NEWLINE_CODE;
    end else if ($urandom_range(0, 99) < 70) begin
      r.char_code = 8'($urandom_range(32, 126));
    end
    return r;
  endfunction

  task automatic add_dir(input logic cmd, input logic [7:0] code, input logic [10:0] idx,
                         input logic has, input logic [15:0] cell_exp, input int row,
                         input int col);
    dir_row_t d;
    d.req             = '{command: cmd, char_code: code, read_index: idx};
    d.has_exp         = has;
    d.exp.cell_value  = cell_exp;
    d.exp.cursor_row  = 5'(row);
    d.exp.cursor_col  = 7'(col);
    d.exp.scrolled    = 1'b0;
    dir_tab.push_back(d);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_request(input ttw_pkg::req_t r, input logic has,
                               input ttw_pkg::rsp_t exp, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    in_req      = r;
    cur_has_exp = has;
    cur_exp     = exp;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_color(input logic [7:0] value);
    start = 1'b0;
    while (screen_rsp_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    ttw_pkg::rsp_t want;
    if (rst_n) begin
      if (cfg_we) text_attr = cfg_wdata;
      if (start && !busy) begin
        want = terminal_step(in_req);
        screen_rsp_q.push_back(cur_has_exp ? cur_exp : want);
      end
      if (out_strobe) begin
        if (screen_rsp_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_rsp);
          mismatch_cnt++;
        end else begin
          want = screen_rsp_q.pop_front();
          if (out_rsp.cell_value !== want.cell_value) begin
            $display("%0t: cell_value exp %h act %h", $time, want.cell_value,
                     out_rsp.cell_value);
            mismatch_cnt++;
          end
          if (out_rsp.cursor_row !== want.cursor_row) begin
            $display("%0t: cursor_row exp %0d act %0d", $time, want.cursor_row,
                     out_rsp.cursor_row);
            mismatch_cnt++;
          end
          if (out_rsp.cursor_col !== want.cursor_col) begin
            $display("%0t: cursor_col exp %0d act %0d", $time, want.cursor_col,
                     out_rsp.cursor_col);
            mismatch_cnt++;
          end
          if (out_rsp.scrolled !== want.scrolled) begin
            $display("%0t: scrolled exp %b act %b", $time, want.scrolled, out_rsp.scrolled);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int            i;
    int            ph;
    int            n;
    int            gap;
    int            nl_pct;
    int            burst_left;
    ttw_pkg::req_t r;
    start        = 1'b0;
    in_req       = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    cur_has_exp  = 1'b0;
    cur_exp      = '0;
    rst_n        = 1'b0;
    mismatch_cnt = 0;
    stall_cnt    = 0;
    burst_left   = 0;
    cur_row      = 0;
    cur_col      = 0;
    text_attr    = ttw_pkg::COLOR_RESET;
    for (i = 0; i < CELLS; i++) screen_mem[i] = {ttw_pkg::COLOR_RESET, ttw_pkg::SPACE_CODE};

    // blank store after reset, out-of-range reads, puts and a newline read back, high bytes kept unsigned
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd0,    1'b1, 16'h0720, 0, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd1999, 1'b1, 16'h0720, 0, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd2000, 1'b1, 16'h0000, 0, 0);
    add_dir(ttw_pkg::CMD_READ, 8'hFF, 11'd2047, 1'b1, 16'h0000, 0, 0);
    add_dir(ttw_pkg::CMD_PUT,  8'h41, 11'd2047, 1'b1, 16'h0000, 0, 1);
    add_dir(ttw_pkg::CMD_PUT,  8'hFF, 11'd0,    1'b1, 16'h0000, 0, 2);
    add_dir(ttw_pkg::CMD_PUT,  8'h80, 11'd0,    1'b1, 16'h0000, 0, 3);
    add_dir(ttw_pkg::CMD_PUT,  8'h00, 11'd0,    1'b1, 16'h0000, 0, 4);
    add_dir(ttw_pkg::CMD_PUT,  ttw_pkg::NEWLINE_CODE, 11'd5, 1'b1, 16'h0000, 1, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd0,    1'b1, 16'h0741, 1, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd1,    1'b1, 16'h07FF, 1, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd2,    1'b1, 16'h0780, 1, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd3,    1'b1, 16'h0700, 1, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd4,    1'b1, 16'h0720, 1, 0);
    add_dir(ttw_pkg::CMD_PUT,  8'h7F, 11'd0,    1'b0, 16'h0000, 0, 0);
    add_dir(ttw_pkg::CMD_PUT,  ttw_pkg::NEWLINE_CODE, 11'd0, 1'b0, 16'h0000, 0, 0);
    add_dir(ttw_pkg::CMD_PUT,  ttw_pkg::NEWLINE_CODE, 11'd0, 1'b0, 16'h0000, 0, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd80,   1'b0, 16'h0000, 0, 0);
    add_dir(ttw_pkg::CMD_READ, 8'h00, 11'd81,   1'b0, 16'h0000, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      drive_request(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp,
                    $urandom_range(0, 5));

    for (ph = 0; ph < N_PHASE; ph++) begin
      case (ph)
        0: nl_pct = 15;
        1: begin set_color(8'hFF); nl_pct = 40; end
        2: begin set_color(8'h00); nl_pct = 0;  end
        default: begin set_color(8'($urandom_range(1, 254))); nl_pct = 25; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0 && $urandom_range(0, 39) == 0) burst_left = 15;
        gap = $urandom_range(0, 5);
        if (burst_left > 0) begin
          gap = 0;
          burst_left--;
        end
        r = rand_request(nl_pct);
        drive_request(r, 1'b0, '0, gap);
      end
    end

    start = 1'b0;
    while (screen_rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### text_terminal_writer_core.f
hw/rtl/ttw_pkg.sv
hw/rtl/text_terminal_writer_core.sv
verif/tb_text_terminal_writer_core.sv
